// ===== src/rts_pkg.sv =====
package rts_pkg;

	localparam int unsigned COUNT_BITS_DEF = 24;
	localparam int unsigned OUT_CNT_W      = 24;
	localparam int unsigned INDEX_W        = 16;
	localparam int unsigned TOKEN_W        = 16;
	localparam int unsigned FRAC_W         = 16;
	localparam int unsigned QUOT_W         = 32;
	localparam int unsigned COEF_W         = 23;
	localparam int unsigned ACC_W          = 64;

	// Q16.16 coefficients
	localparam logic [COEF_W-1:0] K_EASE_A  = 23'd5544346;  // 84.6
	localparam logic [COEF_W-1:0] K_EASE_B  = 23'd66519;    // 1.015
	localparam logic [COEF_W-1:0] K_GRADE_A = 23'd773325;   // 11.8
	localparam logic [COEF_W-1:0] K_GRADE_B = 23'd25559;    // 0.39
	// offsets already in Q32.32
	localparam logic signed [ACC_W-1:0] EASE_BASE  = 64'sd13555139 <<< 16;   // 206.835
	localparam logic signed [ACC_W-1:0] GRADE_BASE = -(64'sd1021706 <<< 16); // -15.59

	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_E     = 8'h65;

	typedef struct packed {
		logic [7:0] text_char;
		logic       last;
	} in_item_t;

	typedef struct packed {
		logic [OUT_CNT_W-1:0]      syllable_count;
		logic [OUT_CNT_W-1:0]      word_count_lines;
		logic [OUT_CNT_W-1:0]      word_count_spaces;
		logic [OUT_CNT_W-1:0]      sentence_count;
		logic signed [INDEX_W-1:0] ease_index;
		logic signed [INDEX_W-1:0] grade_x10;
		logic                      divide_fault;
	} out_item_t;

	typedef enum logic [5:0] {
		ST_ACC   = 6'b000001,
		ST_DIV   = 6'b000010,
		ST_MUL   = 6'b000100,
		ST_SCALE = 6'b001000,
		ST_ROUND = 6'b010000,
		ST_FLUSH = 6'b100000
	} state_t;

endpackage

// ===== src/rts_stream_if.sv =====
interface rts_stream_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ===== src/readability_text_statistics.sv =====
// Channel  | Dir | Payload                                       | Transfer
// ---------+-----+-----------------------------------------------+-------------------
// in_ch    | in  | text_char[7:0], last                          | valid & ready
// out_ch   | out | 4 counts [23:0], ease_index, grade_x10, fault | valid & ready
//
// One byte is taken per cycle while the block is accumulating.
// A byte with last set starts the finish sequence: two restoring divisions
// through one shared divider, steps on one shared 32x23 multiplier, a scale
// and a round step, then the result is loaded into the output register
// (directly, with divide_fault set, if there are no line words or no marks).
// in_ch.ready is low during that sequence and while a finished result waits
// for a free output register; a stalled output does not block bytes of the
// next text. arst_n clears all counts and the sequencer; no clearing pass.
module readability_text_statistics #(
	parameter int unsigned COUNT_BITS = rts_pkg::COUNT_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	rts_stream_if.sink   in_ch,
	rts_stream_if.source out_ch
);
	import rts_pkg::*;

	// divider sizing: numerator is count<<16 plus half the divisor
	localparam int unsigned NUM_W = COUNT_BITS + FRAC_W + 1;
	localparam int unsigned CNT_W = $clog2(NUM_W + 1);
	localparam int unsigned SUM_W = ((COUNT_BITS > TOKEN_W) ? COUNT_BITS : TOKEN_W) + 1;
	localparam int unsigned PROD_W = QUOT_W + COEF_W;
	localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

	// open line token plus line-word totals
	typedef struct packed {
		logic                  held_valid;
		logic [7:0]            held_char;
		logic [TOKEN_W-1:0]    tok;
		logic                  dig;
		logic [COUNT_BITS-1:0] syl;
		logic [COUNT_BITS-1:0] words;
	} line_t;

	// open space token plus space-word total
	typedef struct packed {
		logic                  open;
		logic                  dig;
		logic [COUNT_BITS-1:0] words;
	} space_t;

	// ---------------------------------------------------------------- helpers
	function automatic logic is_vowel(logic [7:0] c);
		logic [7:0] l;
		l = c | 8'h20;
		return (c >= 8'h41) && (l == 8'h61 || l == 8'h65 || l == 8'h69 ||
			l == 8'h6F || l == 8'h75 || l == 8'h79);
	endfunction

	function automatic logic is_mark(logic [7:0] c);
		return c == 8'h2E || c == 8'h21 || c == 8'h3F || c == 8'h3B || c == 8'h3A;
	endfunction

	function automatic logic is_digit(logic [7:0] c);
		return c >= 8'h30 && c <= 8'h39;
	endfunction

	function automatic logic [COUNT_BITS-1:0] sat_inc(logic [COUNT_BITS-1:0] v);
		return (&v) ? v : v + COUNT_BITS'(1);
	endfunction

	function automatic logic [TOKEN_W-1:0] tok_inc(logic [TOKEN_W-1:0] v);
		return (&v) ? v : v + TOKEN_W'(1);
	endfunction

	function automatic logic [COUNT_BITS-1:0] sat_add(logic [COUNT_BITS-1:0] a,
			logic [TOKEN_W-1:0] b);
		logic [SUM_W-1:0] s;
		s = SUM_W'(a) + SUM_W'(b);
		return (s > SUM_W'(CNT_MAX)) ? CNT_MAX : s[COUNT_BITS-1:0];
	endfunction

	function automatic line_t close_line(line_t l);
		line_t r;
		r = l;
		if (l.held_valid) begin
			if (is_vowel(l.held_char)) r.tok = tok_inc(l.tok);
			if (!l.dig) begin
				if (l.held_char == CH_E && r.tok > TOKEN_W'(1)) r.tok = r.tok - TOKEN_W'(1);
				r.syl   = sat_add(l.syl, r.tok);
				r.words = sat_inc(l.words);
			end
		end
		r.held_valid = 1'b0;
		r.held_char  = '0;
		r.tok        = '0;
		r.dig        = 1'b0;
		return r;
	endfunction

	function automatic space_t close_space(space_t s);
		space_t r;
		r = s;
		if (s.open && !s.dig) r.words = sat_inc(s.words);
		r.open = 1'b0;
		r.dig  = 1'b0;
		return r;
	endfunction

	function automatic logic [OUT_CNT_W-1:0] out24(logic [COUNT_BITS-1:0] v);
		logic [32:0] w;
		w = 33'(v);
		return (w > 33'hFF_FFFF) ? '1 : w[OUT_CNT_W-1:0];
	endfunction

	// Q32.32 to integer, half away from zero, clamp to 16 bits
	function automatic logic signed [INDEX_W-1:0] round_sat(logic signed [ACC_W-1:0] v);
		logic [ACC_W-1:0] mag;
		logic [ACC_W-1:0] r;
		mag = v[ACC_W-1] ? ACC_W'(-v) : ACC_W'(v);
		r   = (mag + (ACC_W'(1) << 31)) >> 32;
		if (!v[ACC_W-1]) begin
			return (r > ACC_W'(32767)) ? 16'sh7FFF : INDEX_W'(r);
		end else begin
			return (r > ACC_W'(32768)) ? 16'sh8000 : INDEX_W'(-r);
		end
	endfunction

	// ---------------------------------------------------------------- state
	state_t                  state_q;
	line_t                   line_q, line_n;
	space_t                  space_q, space_n;
	logic [COUNT_BITS-1:0]   sent_q, sent_n;

	logic [NUM_W-1:0]        div_n_q;     // dividend bits out, quotient bits in
	logic [COUNT_BITS-1:0]   div_rem_q;
	logic [COUNT_BITS-1:0]   div_den_q;
	logic [CNT_W-1:0]        div_cnt_q;
	logic                    div_sel_q;   // 0: syllables/word, 1: words/sentence

	logic [QUOT_W-1:0]       a_q, b_q;
	logic [2:0]              step_q;
	logic [PROD_W-1:0]       prod_q;
	logic signed [ACC_W-1:0] acc_e_q, acc_g_q;

	logic signed [INDEX_W-1:0] ease_q, grade_q;
	logic                    fault_q;

	out_item_t               out_q;
	logic                    out_valid_q;

	in_item_t                in_item;
	logic                    in_xfer;
	logic                    load_out;

	assign in_item     = in_ch.data;
	assign in_ch.ready = (state_q == ST_ACC);
	assign in_xfer     = in_ch.valid && in_ch.ready;
	assign load_out    = (state_q == ST_FLUSH) && (!out_valid_q || out_ch.ready);

	assign out_ch.valid = out_valid_q;
	assign out_ch.data  = out_q;

	// ---------------------------------------------------------------- per-byte update
	always_comb begin
		logic [7:0] c;
		logic       sp;
		logic       nl;
		c  = in_item.text_char;
		sp = (c == CH_SPACE);
		nl = (c == CH_NL);

		sent_n = is_mark(c) ? sat_inc(sent_q) : sent_q;

		space_n = space_q;
		if (sp) begin
			space_n = close_space(space_q);
		end else begin
			space_n.open = 1'b1;
			if (is_digit(c)) space_n.dig = 1'b1;
		end

		line_n = line_q;
		if (sp || nl) begin
			line_n = close_line(line_q);
		end else begin
			if (line_q.held_valid && is_vowel(line_q.held_char) && !is_vowel(c) && !is_mark(c))
				line_n.tok = tok_inc(line_q.tok);
			line_n.held_char  = c;
			line_n.held_valid = 1'b1;
			if (is_digit(c)) line_n.dig = 1'b1;
		end

		// last byte closes both open tokens
		if (in_item.last) begin
			line_n  = close_line(line_n);
			space_n = close_space(space_n);
		end
	end

	// ---------------------------------------------------------------- shared divider step
	logic [COUNT_BITS:0]   div_trial;
	logic [COUNT_BITS:0]   div_diff;
	logic                  div_qbit;
	logic [NUM_W-1:0]      div_n_next;
	logic [COUNT_BITS-1:0] div_rem_next;
	logic [63:0]           div_quot;
	logic [QUOT_W-1:0]     div_sat;

	always_comb begin
		div_trial    = {div_rem_q, div_n_q[NUM_W-1]};
		div_diff     = div_trial - {1'b0, div_den_q};
		div_qbit     = (div_trial >= {1'b0, div_den_q});
		div_rem_next = div_qbit ? div_diff[COUNT_BITS-1:0] : div_trial[COUNT_BITS-1:0];
		div_n_next   = {div_n_q[NUM_W-2:0], div_qbit};
		div_quot     = 64'(div_n_next);
		div_sat      = (|div_quot[63:QUOT_W]) ? '1 : div_quot[QUOT_W-1:0];
	end

	function automatic logic [NUM_W-1:0] div_num(logic [COUNT_BITS-1:0] hi,
			logic [COUNT_BITS-1:0] den);
		return (NUM_W'(hi) << FRAC_W) + NUM_W'(den >> 1);
	endfunction

	// ---------------------------------------------------------------- shared multiplier
	logic [QUOT_W-1:0] mul_x;
	logic [COEF_W-1:0] mul_k;
	logic [PROD_W-1:0] mul_p;

	always_comb begin
		mul_x = step_q[0] ? b_q : a_q;
		case (step_q[1:0])
			2'd0:    mul_k = K_EASE_A;
			2'd1:    mul_k = K_EASE_B;
			2'd2:    mul_k = K_GRADE_A;
			default: mul_k = K_GRADE_B;
		endcase
		mul_p = PROD_W'(mul_x) * PROD_W'(mul_k);
	end

	// ---------------------------------------------------------------- sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_ACC;
			line_q      <= '0;
			space_q     <= '0;
			sent_q      <= '0;
			div_cnt_q   <= '0;
			div_sel_q   <= 1'b0;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_out) out_valid_q <= 1'b1;
			else if (out_ch.ready) out_valid_q <= 1'b0;

			case (state_q)
				ST_ACC: begin
					if (in_xfer) begin
						line_q  <= line_n;
						space_q <= space_n;
						sent_q  <= sent_n;
						if (in_item.last) begin
							if (line_n.words == '0 || sent_n == '0) begin
								state_q <= ST_FLUSH;
							end else begin
								div_sel_q <= 1'b0;
								div_cnt_q <= CNT_W'(NUM_W);
								state_q   <= ST_DIV;
							end
						end
					end
				end
				ST_DIV: begin
					if (div_cnt_q == CNT_W'(1)) begin
						if (!div_sel_q) begin
							div_sel_q <= 1'b1;
							div_cnt_q <= CNT_W'(NUM_W);
						end else begin
							step_q  <= '0;
							state_q <= ST_MUL;
						end
					end else begin
						div_cnt_q <= div_cnt_q - CNT_W'(1);
					end
				end
				ST_MUL: begin
					step_q <= step_q + 3'd1;
					if (step_q == 3'd4) state_q <= ST_SCALE;
				end
				ST_SCALE: state_q <= ST_ROUND;
				ST_ROUND: state_q <= ST_FLUSH;
				ST_FLUSH: begin
					if (load_out) begin
						line_q  <= '0;
						space_q <= '0;
						sent_q  <= '0;
						state_q <= ST_ACC;
					end
				end
				default: state_q <= ST_ACC;
			endcase
		end
	end

	// datapath registers, no reset
	always_ff @(posedge clk) begin
		case (state_q)
			ST_ACC: begin
				div_n_q   <= div_num(line_n.syl, line_n.words);
				div_den_q <= line_n.words;
				div_rem_q <= '0;
				ease_q    <= '0;
				grade_q   <= '0;
				fault_q   <= 1'b1;
			end
			ST_DIV: begin
				if (div_cnt_q == CNT_W'(1) && !div_sel_q) begin
					// first quotient done, load words/sentence
					a_q       <= div_sat;
					div_n_q   <= div_num(space_q.words, sent_q);
					div_den_q <= sent_q;
					div_rem_q <= '0;
				end else begin
					div_n_q   <= div_n_next;
					div_rem_q <= div_rem_next;
					if (div_cnt_q == CNT_W'(1)) begin
						b_q     <= div_sat;
						acc_e_q <= EASE_BASE;
						acc_g_q <= GRADE_BASE;
					end
				end
			end
			ST_MUL: begin
				prod_q <= mul_p;
				case (step_q)
					3'd1:    acc_e_q <= acc_e_q - ACC_W'(prod_q);
					3'd2:    acc_e_q <= acc_e_q - ACC_W'(prod_q);
					3'd3:    acc_g_q <= acc_g_q + ACC_W'(prod_q);
					3'd4:    acc_g_q <= acc_g_q + ACC_W'(prod_q);
					default: ;
				endcase
			end
			ST_SCALE: acc_g_q <= (acc_g_q <<< 3) + (acc_g_q <<< 1);
			ST_ROUND: begin
				ease_q  <= round_sat(acc_e_q);
				grade_q <= round_sat(acc_g_q);
				fault_q <= 1'b0;
			end
			default: ;
		endcase

		if (load_out) begin
			out_q.syllable_count    <= out24(line_q.syl);
			out_q.word_count_lines  <= out24(line_q.words);
			out_q.word_count_spaces <= out24(space_q.words);
			out_q.sentence_count    <= out24(sent_q);
			out_q.ease_index        <= ease_q;
			out_q.grade_x10         <= grade_q;
			out_q.divide_fault      <= fault_q;
		end
	end

endmodule

// ===== sim/readability_text_statistics_tb.sv =====
`timescale 1ns / 1ps

module readability_text_statistics_tb;
	import rts_pkg::*;

	// Counter width of the instance (default parameter)
	localparam int unsigned CNT_BITS = 24;
	localparam longint unsigned CNT_TOP = (64'd1 << CNT_BITS) - 1;
	localparam longint unsigned OUT_TOP = 64'hFF_FFFF;
	localparam int unsigned TOKEN_TOP = 'hFFFF;

	// Q16.16 constants of the two formulas
	localparam longint EASE_OFS = 13555139;   // 206.835
	localparam longint EASE_A = 5544346;      // 84.6
	localparam longint EASE_B = 66519;        // 1.015
	localparam longint GRADE_A = 773325;      // 11.8
	localparam longint GRADE_B = 25559;       // 0.39
	localparam longint GRADE_OFS = 1021706;   // 15.59

	// Settling wait at the end of the run
	localparam int unsigned SETTLE_CYCLES = 2 * CNT_BITS + 80;
	localparam int unsigned PHASE_BYTES = 150;
	localparam int unsigned PLAN_ROWS = 25;

	typedef struct {
		logic [7:0] text_char;
		logic       last;
		bit         typed;     // want holds a hand-written result
		out_item_t  want;
	} plan_row_t;

	logic clk = 1'b0;
	logic arst_n;

	rts_stream_if #(.T(in_item_t))  in_if ();
	rts_stream_if #(.T(out_item_t)) out_if ();

	readability_text_statistics i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_if),
		.out_ch (out_if)
	);

	always #2 clk = ~clk;

	// Results still owed by the block, oldest first
	out_item_t expected_stats_q [$];
	int unsigned fail_count = 0;
	int unsigned bytes_sent = 0;
	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;
	plan_row_t plan [PLAN_ROWS];

	// ------------------------------------------------------------------
	// Text statistics predictor: running counts of the current text
	// ------------------------------------------------------------------
	logic [7:0]      tok_last_byte;    // latest byte of the open line word
	bit              tok_open;
	int unsigned     tok_syllables;
	bit              line_has_digit;
	bit              space_has_digit;
	bit              space_open;
	longint unsigned syllables_seen;
	longint unsigned line_words_seen;
	longint unsigned space_words_seen;
	longint unsigned marks_seen;

	function automatic bit is_vowel(logic [7:0] c);
		logic [7:0] lc;
		lc = c | 8'h20;
		if (c < "A")
			return 1'b0;
		return lc == "a" || lc == "e" || lc == "i" || lc == "o" || lc == "u" || lc == "y";
	endfunction

	function automatic bit is_mark(logic [7:0] c);
		return c == "." || c == "!" || c == "?" || c == ";" || c == ":";
	endfunction

	function automatic bit is_digit(logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic longint unsigned count_up(longint unsigned v, longint unsigned n);
		return (v + n > CNT_TOP) ? CNT_TOP : v + n;
	endfunction

	function automatic void reset_text_state();
		tok_last_byte = '0;
		tok_open = 1'b0;
		tok_syllables = 0;
		line_has_digit = 1'b0;
		space_has_digit = 1'b0;
		space_open = 1'b0;
		syllables_seen = 0;
		line_words_seen = 0;
		space_words_seen = 0;
		marks_seen = 0;
	endfunction

	function automatic void bump_token_syllables();
		if (tok_syllables < TOKEN_TOP)
			tok_syllables++;
	endfunction

	// Word split at space or newline ends: trailing vowel counts, silent 'e' drops one
	function automatic void end_line_word();
		if (tok_open) begin
			if (is_vowel(tok_last_byte))
				bump_token_syllables();
			if (!line_has_digit) begin
				if (tok_last_byte == "e" && tok_syllables > 1)
					tok_syllables--;
				syllables_seen = count_up(syllables_seen, 64'(tok_syllables));
				line_words_seen = count_up(line_words_seen, 64'd1);
			end
		end
		tok_open = 1'b0;
		tok_last_byte = '0;
		tok_syllables = 0;
		line_has_digit = 1'b0;
	endfunction

	function automatic void end_space_word();
		if (space_open && !space_has_digit)
			space_words_seen = count_up(space_words_seen, 64'd1);
		space_open = 1'b0;
		space_has_digit = 1'b0;
	endfunction

	// Q16.16 quotient, round to nearest, capped to 32 bits
	function automatic longint q16_ratio(longint unsigned num, longint unsigned den);
		longint unsigned q;
		q = ((num << 16) + (den >> 1)) / den;
		return (q > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : longint'(q);
	endfunction

	// Q32.32 to integer, half away from zero, clamped to int16
	function automatic logic signed [15:0] round_q32(longint v);
		longint r;
		if (v >= 0)
			r = (v + (64'sd1 <<< 31)) >>> 32;
		else
			r = -((-v + (64'sd1 <<< 31)) >>> 32);
		if (r > 32767)
			r = 32767;
		if (r < -32768)
			r = -32768;
		return r[15:0];
	endfunction

	// Feeds one byte through the predictor; returns 1 when it closes a text
	function automatic bit count_text_byte(input logic [7:0] c, input logic fin,
			output out_item_t stats);
		bit  fault;
		longint a;
		longint b;
		logic signed [15:0] ease;
		logic signed [15:0] grade;

		stats = '0;
		if (is_mark(c))
			marks_seen = count_up(marks_seen, 64'd1);

		if (c == " ") begin
			end_space_word();
		end else begin
			space_open = 1'b1;
			if (is_digit(c))
				space_has_digit = 1'b1;
		end

		if (c == " " || c == "\n") begin
			end_line_word();
		end else begin
			// vowel run ends on a non-vowel byte; a sentence mark swallows it
			if (tok_open && is_vowel(tok_last_byte) && !is_vowel(c) && !is_mark(c))
				bump_token_syllables();
			tok_last_byte = c;
			tok_open = 1'b1;
			if (is_digit(c))
				line_has_digit = 1'b1;
		end

		if (!fin)
			return 1'b0;

		end_line_word();
		end_space_word();

		fault = line_words_seen == 0 || marks_seen == 0;
		ease = '0;
		grade = '0;
		if (!fault) begin
			a = q16_ratio(syllables_seen, line_words_seen);
			b = q16_ratio(space_words_seen, marks_seen);
			ease = round_q32((EASE_OFS <<< 16) - a * EASE_A - b * EASE_B);
			grade = round_q32((a * GRADE_A + b * GRADE_B - (GRADE_OFS <<< 16)) * 10);
		end

		stats.syllable_count = OUT_CNT_W'((syllables_seen > OUT_TOP) ? OUT_TOP : syllables_seen);
		stats.word_count_lines =
			OUT_CNT_W'((line_words_seen > OUT_TOP) ? OUT_TOP : line_words_seen);
		stats.word_count_spaces =
			OUT_CNT_W'((space_words_seen > OUT_TOP) ? OUT_TOP : space_words_seen);
		stats.sentence_count = OUT_CNT_W'((marks_seen > OUT_TOP) ? OUT_TOP : marks_seen);
		stats.ease_index = ease;
		stats.grade_x10 = grade;
		stats.divide_fault = fault;

		reset_text_state();
		return 1'b1;
	endfunction

	// ------------------------------------------------------------------
	// Directed table helpers
	// ------------------------------------------------------------------
	function automatic out_item_t stats_of(int unsigned syl, int unsigned lw, int unsigned sw,
			int unsigned sc, int ease, int grade, bit fault);
		out_item_t s;
		s.syllable_count = OUT_CNT_W'(syl);
		s.word_count_lines = OUT_CNT_W'(lw);
		s.word_count_spaces = OUT_CNT_W'(sw);
		s.sentence_count = OUT_CNT_W'(sc);
		s.ease_index = INDEX_W'(ease);
		s.grade_x10 = INDEX_W'(grade);
		s.divide_fault = fault;
		return s;
	endfunction

	// row checked by the predictor
	function automatic plan_row_t text_row(logic [7:0] c, logic fin);
		plan_row_t r;
		r.text_char = c;
		r.last = fin;
		r.typed = 1'b0;
		r.want = '0;
		return r;
	endfunction

	// closing row with its result written out
	function automatic plan_row_t known_row(logic [7:0] c, out_item_t want);
		plan_row_t r;
		r.text_char = c;
		r.last = 1'b1;
		r.typed = 1'b1;
		r.want = want;
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Sender: one byte per call, valid stays up into the next call unless
	// the next call idles first (no lower/raise within one step)
	// ------------------------------------------------------------------
	task automatic send_byte(input logic [7:0] c, input logic fin, input bit typed,
			input out_item_t want);
		in_item_t  beat;
		out_item_t stats;

		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_if.valid <= 1'b0;
			@(posedge clk);
		end
		beat.text_char = c;
		beat.last = fin;
		in_if.valid <= 1'b1;
		in_if.data <= beat;
		@(posedge clk);
		while (!in_if.ready)
			@(posedge clk);
		// transfer taken at this edge
		if (count_text_byte(c, fin, stats))
			expected_stats_q.insert(expected_stats_q.size(), typed ? want : stats);
		bytes_sent++;
	endtask

	function automatic logic [7:0] pick_text_byte(bit noisy);
		string vowels;
		string consonants;
		string marks;
		int unsigned roll;

		vowels = "aeiouyAEIOUY";
		consonants = "bcdfghjklmnpqrstvwxzBCDHLMNPRST";
		marks = ".!?;:";
		if (noisy)
			return 8'($urandom_range(0, 255));
		roll = $urandom_range(0, 99);
		if (roll < 22)
			return vowels[$urandom_range(0, vowels.len() - 1)];
		if (roll < 30)
			return "e";
		if (roll < 55)
			return consonants[$urandom_range(0, consonants.len() - 1)];
		if (roll < 72)
			return " ";
		if (roll < 77)
			return "\n";
		if (roll < 85)
			return marks[$urandom_range(0, marks.len() - 1)];
		if (roll < 89)
			return 8'($urandom_range("0", "9"));
		return 8'($urandom_range(0, 255));
	endfunction

	// Mostly short word-like texts, now and then a longer one or pure noise
	task automatic send_random_text();
		int unsigned len;
		bit noisy;
		out_item_t none;

		none = '0;
		len = ($urandom_range(0, 15) == 0) ? $urandom_range(31, 90) : $urandom_range(1, 30);
		noisy = ($urandom_range(0, 9) == 0);
		for (int unsigned i = 0; i < len; i++)
			send_byte(pick_text_byte(noisy), i == len - 1, 1'b0, none);
	endtask

	// ------------------------------------------------------------------
	// Receiver and result check
	// ------------------------------------------------------------------
	task automatic flag_field(string field, logic signed [63:0] want, logic signed [63:0] got);
		$error("%s: expected %0d, got %0d", field, want, got);
		fail_count++;
	endtask

	task automatic check_stats(out_item_t want, out_item_t got);
		if (got.syllable_count !== want.syllable_count)
			flag_field("syllable_count", 64'(want.syllable_count), 64'(got.syllable_count));
		if (got.word_count_lines !== want.word_count_lines)
			flag_field("word_count_lines", 64'(want.word_count_lines),
				64'(got.word_count_lines));
		if (got.word_count_spaces !== want.word_count_spaces)
			flag_field("word_count_spaces", 64'(want.word_count_spaces),
				64'(got.word_count_spaces));
		if (got.sentence_count !== want.sentence_count)
			flag_field("sentence_count", 64'(want.sentence_count), 64'(got.sentence_count));
		if (got.ease_index !== want.ease_index)
			flag_field("ease_index", 64'(want.ease_index), 64'(got.ease_index));
		if (got.grade_x10 !== want.grade_x10)
			flag_field("grade_x10", 64'(want.grade_x10), 64'(got.grade_x10));
		if (got.divide_fault !== want.divide_fault)
			flag_field("divide_fault", 64'(want.divide_fault), 64'(got.divide_fault));
	endtask

	// valid/ready read here are the values from before the edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_if.ready <= 1'b0;
		end else begin
			if (out_if.valid && out_if.ready) begin
				if (expected_stats_q.size() == 0) begin
					$error("result transfer with no text closed");
					fail_count++;
				end else begin
					check_stats(expected_stats_q.pop_front(), out_if.data);
				end
			end
			out_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------
	initial begin
		int unsigned idle_by_phase [4];
		int unsigned stall_by_phase [4];
		int unsigned phase_end;

		idle_by_phase = '{0, 88, 0, 26};
		stall_by_phase = '{0, 0, 88, 26};

		arst_n = 1'b0;
		in_if.valid = 1'b0;
		in_if.data = '0;
		reset_text_state();

		// Lone delimiters and a lone digit leave nothing to divide by; a lone
		// mark is one word in one sentence. Then one text running over upper
		// case vowel, a zero byte, a newline inside a space word, 0xFF, a
		// silent 'e', a double space, a digit word, 'y' and the marks ! ? ; :
		plan = '{
			known_row(" ", stats_of(0, 0, 0, 0, 0, 0, 1'b1)),
			known_row("\n", stats_of(0, 0, 1, 0, 0, 0, 1'b1)),
			known_row("9", stats_of(0, 0, 0, 0, 0, 0, 1'b1)),
			known_row(".", stats_of(0, 1, 1, 1, 206, -152, 1'b0)),
			text_row("A", 1'b0),
			text_row("i", 1'b0),
			text_row("r", 1'b0),
			text_row(8'h00, 1'b0),
			text_row("\n", 1'b0),
			text_row(8'hFF, 1'b0),
			text_row("c", 1'b0),
			text_row("a", 1'b0),
			text_row("k", 1'b0),
			text_row("e", 1'b0),
			text_row(" ", 1'b0),
			text_row(" ", 1'b0),
			text_row("4", 1'b0),
			text_row("u", 1'b0),
			text_row("!", 1'b0),
			text_row(" ", 1'b0),
			text_row("y", 1'b0),
			text_row("o", 1'b0),
			text_row("?", 1'b0),
			text_row(";", 1'b0),
			text_row(":", 1'b1)
		};

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i])
			send_byte(plan[i].text_char, plan[i].last, plan[i].typed, plan[i].want);

		// four pressure phases: none, slow sender, slow receiver, both
		for (int p = 0; p < 4; p++) begin
			send_idle_pct = idle_by_phase[p];
			recv_stall_pct = stall_by_phase[p];
			phase_end = bytes_sent + PHASE_BYTES;
			while (bytes_sent < phase_end)
				send_random_text();
		end
		in_if.valid <= 1'b0;

		while (expected_stats_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (fail_count == 0 && expected_stats_q.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	// Watchdog: far beyond the slowest legal run
	initial begin
		#(2_000_000);
		$display("Regression FAIL");
		$finish;
	end

endmodule
